### hw/rtl/uce_pkg.sv
// shared types, constants and helpers for the udp checksum engine
package uce_pkg;

   localparam int WORD_W       = 16;
   localparam int BYTE_W       = 8;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int HDR_SUM_W    = 20;

   localparam logic [WORD_W-1:0] UDP_HEADER_BYTES  = 16'd8;
   localparam logic [WORD_W-1:0] PROTOCOL_RESET    = 16'h0011;
   localparam logic [WORD_W-1:0] COUNT_MAX         = 16'hffff;
   localparam logic [WORD_W-1:0] HEADER_RESET_SUM  =
      PROTOCOL_RESET + UDP_HEADER_BYTES + UDP_HEADER_BYTES;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_ADDRESS      = 3'd0,
      CSR_DESTINATION_ADDRESS = 3'd1,
      CSR_PROTOCOL_WORD       = 3'd2,
      CSR_SOURCE_PORT         = 3'd3,
      CSR_DESTINATION_PORT    = 3'd4,
      CSR_UDP_LENGTH          = 3'd5,
      CSR_CHECKSUM_FIELD      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [WORD_W-1:0] header_sum;
      logic [WORD_W-1:0] udp_length;
   } hdr_type;

   // 16-bit ones' complement add with end-around carry
   function automatic logic [WORD_W-1:0] oc_add16(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
      logic [WORD_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
   endfunction

endpackage

### hw/rtl/uce_csr.sv
// configuration registers and registered pseudo-header sum
module uce_csr
   import uce_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output hdr_type                hdr
);

   logic [31:0]       src_addr_ff;
   logic [31:0]       dst_addr_ff;
   logic [WORD_W-1:0] protocol_ff;
   logic [WORD_W-1:0] sport_ff;
   logic [WORD_W-1:0] dport_ff;
   logic [WORD_W-1:0] udp_length_ff;
   logic [WORD_W-1:0] checksum_field_ff;
   logic [WORD_W-1:0] header_sum_ff;
   logic [WORD_W-1:0] header_sum_in;
   logic [HDR_SUM_W-1:0] total_sum;
   logic [WORD_W:0]   fold_sum;
   logic              write_en;

   assign csr_ready = 1'b1;
   assign write_en  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_addr_ff       <= '0;
         dst_addr_ff       <= '0;
         protocol_ff       <= PROTOCOL_RESET;
         sport_ff          <= '0;
         dport_ff          <= '0;
         udp_length_ff     <= UDP_HEADER_BYTES;
         checksum_field_ff <= '0;
      end else if (write_en) begin
         case (csr_index)
            CSR_SOURCE_ADDRESS:      src_addr_ff       <= csr_data;
            CSR_DESTINATION_ADDRESS: dst_addr_ff       <= csr_data;
            CSR_PROTOCOL_WORD:       protocol_ff       <= csr_data[WORD_W-1:0];
            CSR_SOURCE_PORT:         sport_ff          <= csr_data[WORD_W-1:0];
            CSR_DESTINATION_PORT:    dport_ff          <= csr_data[WORD_W-1:0];
            CSR_UDP_LENGTH:          udp_length_ff     <= csr_data[WORD_W-1:0];
            CSR_CHECKSUM_FIELD:      checksum_field_ff <= csr_data[WORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ten header words, then fold to a 16-bit ones' complement value
   always_comb begin
      total_sum = {4'b0, src_addr_ff[31:16]} + {4'b0, src_addr_ff[15:0]}
                + {4'b0, dst_addr_ff[31:16]} + {4'b0, dst_addr_ff[15:0]}
                + {4'b0, protocol_ff} + {4'b0, udp_length_ff}
                + {4'b0, sport_ff} + {4'b0, dport_ff}
                + {4'b0, udp_length_ff} + {4'b0, checksum_field_ff};
      fold_sum  = {1'b0, total_sum[WORD_W-1:0]}
                + {{(WORD_W-3){1'b0}}, total_sum[HDR_SUM_W-1:WORD_W]};
      header_sum_in = fold_sum[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, fold_sum[WORD_W]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_sum_ff <= HEADER_RESET_SUM;
      end else begin
         header_sum_ff <= header_sum_in;
      end
   end

   assign hdr.header_sum = header_sum_ff;
   assign hdr.udp_length = udp_length_ff;

endmodule

### hw/rtl/uce_accum.sv
// input register, byte pairing accumulator and result register
module uce_accum
   import uce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_payload_byte,
   input  logic              req_last_byte,
   input  hdr_type           hdr,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [WORD_W-1:0] rsp_checksum_value,
   output logic              rsp_length_mismatch
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic [WORD_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] held_ff;
   logic              odd_ff;
   logic [WORD_W-1:0] count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_sum_ff;
   logic              rsp_mismatch_ff;

   logic              take;
   logic              fire;
   logic              out_free;
   logic [WORD_W-1:0] word;
   logic [WORD_W-1:0] total;
   logic              mismatch;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !fire;
   assign take      = req_valid && !req_stall;

   assign in_valid_in  = take || (in_valid_ff && !fire);
   assign rsp_valid_in = (fire && in_last_ff) || (rsp_valid_ff && rsp_stall);

   always_comb begin
      count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 16'd1;
      word     = odd_ff ? {held_ff, in_byte_ff} : {in_byte_ff, 8'h00};
      sum_in   = (odd_ff || in_last_ff) ? oc_add16(sum_ff, word) : sum_ff;
      total    = oc_add16(sum_in, hdr.header_sum);
      // count + 8 against length in 17 bits also covers lengths below eight
      mismatch = ({1'b0, count_in} + {1'b0, UDP_HEADER_BYTES}) != {1'b0, hdr.udp_length};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         odd_ff       <= 1'b0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            if (in_last_ff) begin
               sum_ff   <= '0;
               odd_ff   <= 1'b0;
               count_ff <= '0;
            end else begin
               sum_ff   <= sum_in;
               odd_ff   <= !odd_ff;
               count_ff <= count_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_payload_byte;
         in_last_ff <= req_last_byte;
      end
      if (fire && !odd_ff) begin
         held_ff <= in_byte_ff;
      end
      if (fire && in_last_ff) begin
         rsp_sum_ff      <= ~total;
         rsp_mismatch_ff <= mismatch;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_checksum_value  = rsp_sum_ff;
   assign rsp_length_mismatch = rsp_mismatch_ff;

endmodule

### hw/rtl/udp_checksum_engine.sv
// udp checksum engine top level
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+------------------------------------
//  req     | in        | valid / stall    | payload_byte[7:0], last_byte
//  rsp     | out       | valid / stall    | checksum_value[15:0], length_mismatch
//  csr     | in        | valid / ready    | index[2:0], data[31:0]
//
// one byte per cycle while req_stall is low; a byte goes through an input register
// and then the result register, which raises rsp_valid for the last byte
// a result appears only for a byte marked last; csr_ready is always high
// synchronous reset restores the register defaults and clears the datagram
// a stalled result holds the last byte of the next datagram in the input register
module udp_checksum_engine
   import uce_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_payload_byte,
   input  logic                   req_last_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [WORD_W-1:0]      rsp_checksum_value,
   output logic                   rsp_length_mismatch,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   hdr_type hdr;

   uce_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .hdr       (hdr)
   );

   uce_accum u_accum (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_payload_byte    (req_payload_byte),
      .req_last_byte       (req_last_byte),
      .hdr                 (hdr),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_checksum_value  (rsp_checksum_value),
      .rsp_length_mismatch (rsp_length_mismatch)
   );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// udp checksum engine testbench: directed and random datagrams checked against a predictor
module tb;
   import uce_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int DRAIN_CYCLES        = 6;
   localparam int LONG_HOLD_CYCLES    = 60;
   localparam int RANDOM_ITEMS        = 460;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } payload_item_type;

   typedef struct packed {
      logic [WORD_W-1:0] value;
      logic              mismatch;
   } checksum_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_payload_byte = '0;
   logic                   req_last_byte = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [WORD_W-1:0]      rsp_checksum_value;
   logic                   rsp_length_mismatch;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // register shadow
   logic [31:0]       src_addr   = '0;
   logic [31:0]       dst_addr   = '0;
   logic [WORD_W-1:0] proto_word = PROTOCOL_RESET;
   logic [WORD_W-1:0] sport      = '0;
   logic [WORD_W-1:0] dport      = '0;
   logic [WORD_W-1:0] udp_len    = UDP_HEADER_BYTES;
   logic [WORD_W-1:0] cks_field  = '0;

   // datagram in progress
   logic [31:0]       payload_sum = '0;
   logic [BYTE_W-1:0] high_byte   = '0;
   logic              odd_pending = 1'b0;
   logic [WORD_W-1:0] byte_count  = '0;

   payload_item_type    outgoing_bytes[$];
   checksum_result_type expected_sums[$];
   payload_item_type    next_item;
   checksum_result_type oldest;

   int unsigned bytes_queued  = 0;
   int unsigned bytes_taken   = 0;
   int unsigned send_gap      = 0;
   int unsigned stall_left    = 0;
   int unsigned hold_left     = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_started = 0;
   int          error_count   = 0;
   logic        quiet         = 1'b0;

   udp_checksum_engine dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("tb NOT OK");
      $finish;
   end

   function automatic logic [31:0] add_wrap32(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[31:0] + {31'd0, s[32]};
   endfunction

   function automatic void absorb_byte(logic [BYTE_W-1:0] data, logic last);
      logic [31:0]         total;
      checksum_result_type res;
      if (byte_count != COUNT_MAX) byte_count = byte_count + 1'b1;
      if (odd_pending) begin
         payload_sum = add_wrap32(payload_sum, {16'h0, high_byte, data});
         odd_pending = 1'b0;
         high_byte = '0;
      end else if (last) begin
         payload_sum = add_wrap32(payload_sum, {16'h0, data, 8'h00});
      end else begin
         high_byte = data;
         odd_pending = 1'b1;
      end
      if (last) begin
         total = payload_sum;
         total = add_wrap32(total, {16'h0, src_addr[31:16]});
         total = add_wrap32(total, {16'h0, src_addr[15:0]});
         total = add_wrap32(total, {16'h0, dst_addr[31:16]});
         total = add_wrap32(total, {16'h0, dst_addr[15:0]});
         total = add_wrap32(total, {16'h0, proto_word});
         total = add_wrap32(total, {16'h0, udp_len});
         total = add_wrap32(total, {16'h0, sport});
         total = add_wrap32(total, {16'h0, dport});
         total = add_wrap32(total, {16'h0, udp_len});
         total = add_wrap32(total, {16'h0, cks_field});
         total = {16'h0, total[31:16]} + {16'h0, total[15:0]};
         total = total + {16'h0, total[31:16]};
         res.value = ~total[15:0];
         if (udp_len < UDP_HEADER_BYTES) begin
            res.mismatch = 1'b1;
         end else begin
            res.mismatch = (byte_count != udp_len - UDP_HEADER_BYTES);
         end
         expected_sums.push_back(res);
         payload_sum = '0;
         high_byte = '0;
         odd_pending = 1'b0;
         byte_count = '0;
      end
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            bytes_taken++;
            absorb_byte(req_payload_byte, req_last_byte);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (!quiet && outgoing_bytes.size() != 0 && $urandom_range(5) == 0) begin
               send_gap = $urandom_range(3, 1) - 1;
               req_valid <= 1'b0;
            end else if (outgoing_bytes.size() != 0) begin
               next_item = outgoing_bytes.pop_front();
               req_valid <= 1'b1;
               req_payload_byte <= next_item.data;
               req_last_byte <= next_item.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each result transfer and drives the stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sums.size() == 0) begin
            $display("%0t: result %h/%b, expected none", $time, rsp_checksum_value,
                     rsp_length_mismatch);
            error_count++;
         end else begin
            oldest = expected_sums.pop_front();
            if (rsp_checksum_value !== oldest.value) begin
               $display("%0t: checksum_value expected %h, actual %h", $time, oldest.value,
                        rsp_checksum_value);
               error_count++;
            end
            if (rsp_length_mismatch !== oldest.mismatch) begin
               $display("%0t: length_mismatch expected %b, actual %b", $time, oldest.mismatch,
                        rsp_length_mismatch);
               error_count++;
            end
         end
      end
      if (holds_started != hold_requests) begin
         holds_started = hold_requests;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(5) == 0) begin
         stall_left = $urandom_range(3, 1) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [CSR_DATA_W-1:0] pick_value();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SOURCE_ADDRESS:      src_addr = data;
         CSR_DESTINATION_ADDRESS: dst_addr = data;
         CSR_PROTOCOL_WORD:       proto_word = data[WORD_W-1:0];
         CSR_SOURCE_PORT:         sport = data[WORD_W-1:0];
         CSR_DESTINATION_PORT:    dport = data[WORD_W-1:0];
         CSR_UDP_LENGTH:          udp_len = data[WORD_W-1:0];
         CSR_CHECKSUM_FIELD:      cks_field = data[WORD_W-1:0];
         default: ;
      endcase
   endtask

   // every register to one value, or a random subset to random values
   task automatic program_registers(logic same_value, logic [CSR_DATA_W-1:0] value);
      csr_index_type reg_sel;
      reg_sel = reg_sel.first();
      do begin
         if (same_value) write_csr(reg_sel, value);
         else if ($urandom_range(1)) write_csr(reg_sel, pick_value());
         reg_sel = reg_sel.next();
      end while (reg_sel != reg_sel.first());
   endtask

   task automatic queue_byte(logic [BYTE_W-1:0] data, logic last);
      outgoing_bytes.push_back('{data, last});
      bytes_queued++;
   endtask

   task automatic queue_datagram(int unsigned n);
      for (int unsigned i = 1; i <= n; i++) queue_byte(BYTE_W'($urandom_range(255)), i == n);
   endtask

   // wait until every byte is taken and every result has come out
   task automatic settle();
      do @(posedge clock); while (bytes_taken != bytes_queued || expected_sums.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned n;
      int unsigned copies;
      int unsigned start;
      int unsigned random_items;
      int unsigned random_results;
      logic [CSR_DATA_W-1:0] len_value;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: odd and even datagrams
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hff, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hab, 1'b1);
      queue_byte(8'h12, 1'b0);
      queue_byte(8'h34, 1'b1);
      settle();

      // all registers zero: a zero checksum stays zero, an empty sum gives ffff
      program_registers(1'b1, '0);
      queue_byte(8'hff, 1'b0);
      queue_byte(8'hff, 1'b1);
      queue_byte(8'h00, 1'b1);
      settle();

      program_registers(1'b1, '1);
      queue_byte(8'hff, 1'b0);
      queue_byte(8'hff, 1'b0);
      queue_byte(8'hff, 1'b1);
      settle();

      // length below the header size, and an index past the register list
      write_csr(CSR_UDP_LENGTH, 32'd7);
      write_csr(CSR_UNUSED_INDEX, '1);
      queue_byte(8'h5a, 1'b1);
      settle();
      write_csr(CSR_UDP_LENGTH, 32'd9);
      queue_byte(8'ha5, 1'b1);
      settle();

      // registers written while a datagram is open
      write_csr(CSR_UDP_LENGTH, 32'd12);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'h01, 1'b0);
      queue_byte(8'h7f, 1'b0);
      settle();
      write_csr(CSR_CHECKSUM_FIELD, $urandom());
      write_csr(CSR_SOURCE_PORT, $urandom());
      queue_byte(8'hc3, 1'b1);
      settle();

      random_items = 0;
      random_results = 0;
      while (random_items < RANDOM_ITEMS || random_results < 40) begin
         start = bytes_queued;
         program_registers(1'b0, '0);
         n = ($urandom_range(3) == 0) ? $urandom_range(64, 1) : $urandom_range(12, 1);
         case ($urandom_range(9))
            0:       len_value = $urandom_range(7);
            1, 2:    len_value = pick_value();
            default: len_value = (n + UDP_HEADER_BYTES) | ($urandom() & 32'hffff0000);
         endcase
         write_csr(CSR_UDP_LENGTH, len_value);
         copies = $urandom_range(3, 1);
         repeat (copies) queue_datagram(n);
         if ($urandom_range(4) == 0) begin
            queue_datagram($urandom_range(12, 1));
            copies++;
         end
         random_items += bytes_queued - start;
         random_results += copies;
         settle();
      end

      // result side held off while short datagrams keep coming
      write_csr(CSR_UDP_LENGTH, 32'd9);
      hold_requests++;
      repeat (30) queue_datagram($urandom_range(2, 1));
      settle();

      // closing stretch without idling
      quiet = 1'b1;
      program_registers(1'b0, '0);
      n = $urandom_range(8, 1);
      write_csr(CSR_UDP_LENGTH, n + UDP_HEADER_BYTES);
      repeat (6) queue_datagram(n);
      settle();

      if (error_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/uce_pkg.sv
hw/rtl/uce_csr.sv
hw/rtl/uce_accum.sv
hw/rtl/udp_checksum_engine.sv
tb/tb.sv
